/* rtl/vnf_pkg.sv */
// ----------------------------------------------------------------------------
// vnf_pkg
// Shared types and constants of the two-dimensional fractal value noise unit.
// ----------------------------------------------------------------------------
`default_nettype none

package vnf_pkg;

	// Field widths fixed by the interface.
	localparam int COORD_W   = 32;
	localparam int OCT_CNT_W = 4;
	localparam int LAC_W     = 16;
	localparam int GAIN_W    = 16;
	localparam int NOISE_W   = 17;
	localparam int CFG_IDX_W = 8;
	localparam int CFG_DAT_W = 16;
	localparam int TAB_W     = 32;
	localparam int TERM_W    = 32;
	// Effective octave count, wide enough for the largest supported table.
	localparam int N_W       = 5;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_OCTAVE_COUNT = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_LACUNARITY   = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_GAIN         = CFG_IDX_W'(2);

	// Register values after reset.
	localparam logic [OCT_CNT_W-1:0] OCT_CNT_RST = OCT_CNT_W'(4);
	localparam logic [LAC_W-1:0]     LAC_RST     = LAC_W'(8192);
	localparam logic [GAIN_W-1:0]    GAIN_RST    = GAIN_W'(8192);

	// Unity in Q16.16 (tables) and in Q1.16 (noise values).
	localparam logic [TAB_W-1:0]   TAB_ONE = TAB_W'(65536);
	localparam logic [NOISE_W-1:0] ONE_Q16 = NOISE_W'(65536);

	// Lattice hash.
	localparam logic [31:0] HASH_K1  = 32'd374761393;
	localparam logic [31:0] HASH_K2  = 32'd668265263;
	localparam logic [31:0] HASH_K12 = 32'd1043026656;
	localparam logic [31:0] HASH_K3  = 32'd1274126177;
	localparam int          XS_SHIFT = 13;
	localparam int          HASH_KEEP = 24;

	// Smoothstep: t*t*(3 - 2t) with t in Q0.16.
	localparam logic [17:0] SMOOTH_BASE = 18'd196608;

	// Reciprocal of the amplitude sum: 2^48 / S, one quotient bit per cycle.
	localparam int                    QUO_W     = 49;
	localparam int                    DIV_CNT_W = 6;
	localparam logic [DIV_CNT_W-1:0]  DIV_TOP   = DIV_CNT_W'(QUO_W - 1);

	// Pipeline latencies of the lane and of the final scaling.
	localparam int LANE_LAT  = 11;
	localparam int FINAL_LAT = 2;

	typedef enum logic [1:0] {
		TB_IDLE,
		TB_TABLE,
		TB_DIVIDE
	} tb_state_t;

	typedef struct packed {
		logic             busy;
		logic [N_W-1:0]   n_active;
		logic [TAB_W-1:0] recip;
	} tbl_status_t;

endpackage

`default_nettype wire

/* rtl/vnf_if.sv */
// ----------------------------------------------------------------------------
// vnf_if
// Valid/ready channels of the fractal value noise unit: samples, results and
// configuration writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface vnf_sample_if import vnf_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] x_coord;
	logic signed [COORD_W-1:0] y_coord;

	modport source (output valid, output x_coord, output y_coord, input ready);
	modport sink   (input valid, input x_coord, input y_coord, output ready);
endinterface

interface vnf_result_if import vnf_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [NOISE_W-1:0] noise_value;

	modport source (output valid, output noise_value, input ready);
	modport sink   (input valid, input noise_value, output ready);
endinterface

interface vnf_cfg_if import vnf_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DAT_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* rtl/vnf_table_builder.sv */
// ----------------------------------------------------------------------------
// vnf_table_builder
// Configuration registers, per-octave frequency and amplitude tables and the
// reciprocal of the amplitude sum, rebuilt after reset and on every register write.
// ----------------------------------------------------------------------------
`default_nettype none

module vnf_table_builder import vnf_pkg::*; #(
	parameter int MAX_OCTAVES = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	vnf_cfg_if.sink          cfg,
	output logic [TAB_W-1:0] freq_tab [MAX_OCTAVES],
	output logic [TAB_W-1:0] amp_tab  [MAX_OCTAVES],
	output tbl_status_t      status
);

	localparam int CNT_W = $clog2(MAX_OCTAVES + 1);
	localparam int IDX_W = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;
	localparam int SUM_W = TAB_W + CNT_W;
	localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(MAX_OCTAVES - 1);

	tb_state_t state_q, state_d;

	logic [OCT_CNT_W-1:0] octave_count_q;
	logic [LAC_W-1:0]     lacunarity_q;
	logic [GAIN_W-1:0]    gain_q;

	logic [CNT_W-1:0]     idx_q;
	logic [TAB_W-1:0]     cur_freq_q;
	logic [TAB_W-1:0]     cur_amp_q;
	logic [SUM_W-1:0]     sum_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic [SUM_W-1:0]     rem_q;
	logic [QUO_W-1:0]     quo_q;
	logic [TAB_W-1:0]     recip_q;
	logic [TAB_W-1:0]     freq_tab_q [MAX_OCTAVES];
	logic [TAB_W-1:0]     amp_tab_q  [MAX_OCTAVES];

	logic                 cfg_hit;
	logic [N_W-1:0]       n_active;
	logic [47:0]          freq_prod, amp_prod;
	logic [35:0]          freq_shift;
	logic [33:0]          amp_shift;
	logic [TAB_W-1:0]     freq_next, amp_next;
	logic [SUM_W:0]       trial;
	logic                 quo_bit;
	logic [SUM_W-1:0]     rem_next;
	logic [QUO_W-1:0]     quo_next;
	logic [TAB_W-1:0]     recip_next;

	assign cfg.ready = 1'b1;
	assign cfg_hit   = cfg.valid && (cfg.index == REG_OCTAVE_COUNT ||
		cfg.index == REG_LACUNARITY || cfg.index == REG_GAIN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			octave_count_q <= OCT_CNT_RST;
			lacunarity_q   <= LAC_RST;
			gain_q         <= GAIN_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_OCTAVE_COUNT: octave_count_q <= cfg.data[OCT_CNT_W-1:0];
				REG_LACUNARITY:   lacunarity_q   <= cfg.data[LAC_W-1:0];
				REG_GAIN:         gain_q         <= cfg.data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	assign n_active = (N_W'(octave_count_q) > N_W'(MAX_OCTAVES)) ? N_W'(MAX_OCTAVES)
		: N_W'(octave_count_q);

	// Next table entries, saturated to 32 bits.
	assign freq_prod  = cur_freq_q * lacunarity_q;
	assign amp_prod   = cur_amp_q * gain_q;
	assign freq_shift = freq_prod[47:12];
	assign amp_shift  = amp_prod[47:14];
	assign freq_next  = (|freq_shift[35:32]) ? '1 : freq_shift[31:0];
	assign amp_next   = (|amp_shift[33:32]) ? '1 : amp_shift[31:0];

	// One restoring division step; the dividend is 2^48, so only its top bit is set.
	assign trial      = {rem_q, (div_cnt_q == DIV_TOP)};
	assign quo_bit    = (trial >= {1'b0, sum_q});
	assign rem_next   = quo_bit ? SUM_W'(trial - {1'b0, sum_q}) : trial[SUM_W-1:0];
	assign quo_next   = {quo_q[QUO_W-2:0], quo_bit};
	assign recip_next = (n_active == '0 || sum_q == '0) ? '0
		: ((|quo_next[QUO_W-1:TAB_W]) ? '1 : quo_next[TAB_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= TB_TABLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			TB_IDLE: begin
				if (cfg_hit) state_d = TB_TABLE;
			end
			TB_TABLE: begin
				if (cfg_hit) state_d = TB_TABLE;
				else if (idx_q == LAST_IDX) state_d = TB_DIVIDE;
			end
			TB_DIVIDE: begin
				if (cfg_hit) state_d = TB_TABLE;
				else if (div_cnt_q == '0) state_d = TB_IDLE;
			end
			default: state_d = TB_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			cur_freq_q <= TAB_ONE;
			cur_amp_q  <= TAB_ONE;
			sum_q      <= '0;
			div_cnt_q  <= DIV_TOP;
			rem_q      <= '0;
			quo_q      <= '0;
			recip_q    <= '0;
		end else if (cfg_hit) begin
			idx_q      <= '0;
			cur_freq_q <= TAB_ONE;
			cur_amp_q  <= TAB_ONE;
			sum_q      <= '0;
			div_cnt_q  <= DIV_TOP;
			rem_q      <= '0;
			quo_q      <= '0;
		end else begin
			case (state_q)
				TB_TABLE: begin
					idx_q      <= idx_q + 1'b1;
					cur_freq_q <= freq_next;
					cur_amp_q  <= amp_next;
					if (N_W'(idx_q) < n_active) sum_q <= sum_q + SUM_W'(cur_amp_q);
				end
				TB_DIVIDE: begin
					div_cnt_q <= div_cnt_q - 1'b1;
					rem_q     <= rem_next;
					quo_q     <= quo_next;
					if (div_cnt_q == '0) recip_q <= recip_next;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == TB_TABLE) begin
			freq_tab_q[idx_q[IDX_W-1:0]] <= cur_freq_q;
			amp_tab_q[idx_q[IDX_W-1:0]]  <= cur_amp_q;
		end
	end

	assign freq_tab        = freq_tab_q;
	assign amp_tab         = amp_tab_q;
	assign status.busy     = (state_q != TB_IDLE);
	assign status.n_active = n_active;
	assign status.recip    = recip_q;

`ifndef SYNTHESIS
	// With no octaves selected the finished reciprocal must force the result to zero.
	a_zero_octaves_recip: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == TB_IDLE && n_active == '0) |-> recip_q == '0)
		else $error("reciprocal not zero with zero octaves");

	// The last table step hands over to a full-length division.
	a_table_to_divide: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == TB_TABLE && !cfg_hit && idx_q == LAST_IDX)
		|=> (state_q == TB_DIVIDE && div_cnt_q == DIV_TOP))
		else $error("division did not start after the last table entry");
`endif

endmodule

`default_nettype wire

/* rtl/vnf_octave_lane.sv */
// ----------------------------------------------------------------------------
// vnf_octave_lane
// One octave of value noise: scale, lattice hash, smoothstep blend and
// amplitude weighting, as an eleven-stage pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module vnf_octave_lane import vnf_pkg::*; #(
	parameter int COORD_FRAC_BITS = 16
) (
	input  wire logic                      clk,
	input  wire logic                      en,
	input  wire logic signed [COORD_W-1:0] x_coord,
	input  wire logic signed [COORD_W-1:0] y_coord,
	input  wire logic [TAB_W-1:0]          freq,
	input  wire logic [TAB_W-1:0]          amp,
	input  wire logic                      active,
	output logic [TERM_W-1:0]              term
);

	localparam int SHIFT = COORD_FRAC_BITS + 16;
	localparam logic [49:0] SP_RND     = 50'd1 << 31;
	localparam logic [48:0] CORNER_RND = 49'd1 << 31;
	localparam logic [34:0] LERP_RND   = 35'd32768;
	localparam logic [48:0] AMP_RND    = 49'd32768;

	logic signed [64:0] px_full, py_full;
	logic [31:0]        cx, cy, hbase;
	logic [15:0]        tx, ty;
	logic [31:0]        hsum [4];
	logic [49:0]        spx_rnd, spy_rnd;
	logic [48:0]        csum [4];
	logic [34:0]        asum, bsum, nsum;
	logic [48:0]        tsum;

	logic signed [63:0] px_s1, py_s1;
	logic [31:0]        hx_s2, hy_s2, ttx_s2, tty_s2;
	logic [17:0]        linx_s2, liny_s2;
	logic [31:0]        hs_s3 [4];
	logic [49:0]        spx_s3, spy_s3;
	logic [31:0]        hm_s4 [4];
	logic [16:0]        sx_s4, sy_s4;
	logic [16:0]        c_s5 [4];
	logic [16:0]        sx_s5, sy_s5;
	logic [33:0]        pa0_s6, pa1_s6, pb0_s6, pb1_s6;
	logic [16:0]        sy_s6, sy_s7;
	logic [16:0]        a_s7, b_s7;
	logic [33:0]        pn0_s8, pn1_s8;
	logic [16:0]        noise_s9;
	logic [48:0]        wprod_s10;
	logic [TERM_W-1:0]  term_s11;

	// Stage 1: scale the sample point by the octave frequency.
	assign px_full = x_coord * $signed({1'b0, freq});
	assign py_full = y_coord * $signed({1'b0, freq});

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1 <= px_full[63:0];
			py_s1 <= py_full[63:0];
		end
	end

	// Stage 2: lattice cell and fraction; first hash products, t squared.
	assign cx = 32'(px_s1 >>> SHIFT);
	assign cy = 32'(py_s1 >>> SHIFT);
	assign tx = px_s1[SHIFT-1 -: 16];
	assign ty = py_s1[SHIFT-1 -: 16];

	always_ff @(posedge clk) begin
		if (en) begin
			hx_s2   <= cx * HASH_K1;
			hy_s2   <= cy * HASH_K2;
			ttx_s2  <= tx * tx;
			tty_s2  <= ty * ty;
			linx_s2 <= SMOOTH_BASE - {1'b0, tx, 1'b0};
			liny_s2 <= SMOOTH_BASE - {1'b0, ty, 1'b0};
		end
	end

	// Stage 3: the neighbouring corners differ from the base hash by a constant.
	assign hbase   = hx_s2 + hy_s2;
	assign hsum[0] = hbase;
	assign hsum[1] = hbase + HASH_K1;
	assign hsum[2] = hbase + HASH_K2;
	assign hsum[3] = hbase + HASH_K12;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				hs_s3[k] <= hsum[k] ^ (hsum[k] >> XS_SHIFT);
			end
			spx_s3 <= ttx_s2 * linx_s2;
			spy_s3 <= tty_s2 * liny_s2;
		end
	end

	// Stage 4: final hash multiply and rounded smoothstep weights.
	assign spx_rnd = spx_s3 + SP_RND;
	assign spy_rnd = spy_s3 + SP_RND;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				hm_s4[k] <= hs_s3[k] * HASH_K3;
			end
			sx_s4 <= spx_rnd[48:32];
			sy_s4 <= spy_rnd[48:32];
		end
	end

	// Stage 5: 24-bit hash to Q0.16; v * (2^24 + 1) is a shift and an add.
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			csum[k] = 49'({hm_s4[k][HASH_KEEP-1:0], 24'd0})
				+ 49'(hm_s4[k][HASH_KEEP-1:0]) + CORNER_RND;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				c_s5[k] <= csum[k][48:32];
			end
			sx_s5 <= sx_s4;
			sy_s5 <= sy_s4;
		end
	end

	// Stage 6: products of the blend along x.
	always_ff @(posedge clk) begin
		if (en) begin
			pa0_s6 <= c_s5[0] * (ONE_Q16 - sx_s5);
			pa1_s6 <= c_s5[1] * sx_s5;
			pb0_s6 <= c_s5[2] * (ONE_Q16 - sx_s5);
			pb1_s6 <= c_s5[3] * sx_s5;
			sy_s6  <= sy_s5;
		end
	end

	// Stage 7: rounded x blends.
	assign asum = 35'(pa0_s6) + 35'(pa1_s6) + LERP_RND;
	assign bsum = 35'(pb0_s6) + 35'(pb1_s6) + LERP_RND;

	always_ff @(posedge clk) begin
		if (en) begin
			a_s7  <= asum[32:16];
			b_s7  <= bsum[32:16];
			sy_s7 <= sy_s6;
		end
	end

	// Stage 8: products of the blend along y.
	always_ff @(posedge clk) begin
		if (en) begin
			pn0_s8 <= a_s7 * (ONE_Q16 - sy_s7);
			pn1_s8 <= b_s7 * sy_s7;
		end
	end

	// Stage 9: octave noise value.
	assign nsum = 35'(pn0_s8) + 35'(pn1_s8) + LERP_RND;

	always_ff @(posedge clk) begin
		if (en) noise_s9 <= nsum[32:16];
	end

	// Stage 10: weight by the octave amplitude.
	always_ff @(posedge clk) begin
		if (en) wprod_s10 <= noise_s9 * amp;
	end

	// Stage 11: rounded term; octaves beyond the selected count add nothing.
	assign tsum = wprod_s10 + AMP_RND;

	always_ff @(posedge clk) begin
		if (en) term_s11 <= active ? tsum[47:16] : '0;
	end

	assign term = term_s11;

endmodule

`default_nettype wire

/* rtl/vnf_reduce.sv */
// ----------------------------------------------------------------------------
// vnf_reduce
// Registered adder tree over the octave terms, then normalisation by the
// reciprocal of the amplitude sum with rounding and clamping.
// ----------------------------------------------------------------------------
`default_nettype none

module vnf_reduce import vnf_pkg::*; #(
	parameter int MAX_OCTAVES = 8
) (
	input  wire logic              clk,
	input  wire logic              en,
	input  wire logic [TERM_W-1:0] term [MAX_OCTAVES],
	input  wire logic [TAB_W-1:0]  recip,
	output logic [NOISE_W-1:0]     noise_value
);

	localparam int LEVELS = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 0;
	localparam int LEAVES = 1 << LEVELS;
	localparam int ACC_W  = TERM_W + $clog2(MAX_OCTAVES + 1);
	localparam int HI_W   = ACC_W - 32;
	localparam int R_W    = HI_W + 33;
	localparam logic [64:0] FIN_RND = 65'd1 << 31;

	logic [ACC_W-1:0]     leaf [LEAVES];
	logic [ACC_W-1:0]     acc;
	logic [64:0]          lo_rnd;
	logic [R_W-1:0]       scaled;

	logic [63:0]          prod_lo_s1;
	logic [HI_W+31:0]     prod_hi_s1;
	logic [NOISE_W-1:0]   noise_s2;

	for (genvar k = 0; k < LEAVES; k++) begin : g_leaf
		if (k < MAX_OCTAVES) begin : g_used
			assign leaf[k] = ACC_W'(term[k]);
		end else begin : g_pad
			assign leaf[k] = '0;
		end
	end

	// Heap order: node k sums nodes 2k+1 and 2k+2, the leaves follow the inner nodes.
	if (LEVELS > 0) begin : g_tree
		logic [ACC_W-1:0] node_sum_q [LEAVES-1];
		for (genvar k = 0; k < LEAVES - 1; k++) begin : g_node
			if (2 * k + 1 >= LEAVES - 1) begin : g_from_leaf
				always_ff @(posedge clk) begin
					if (en) begin
						node_sum_q[k] <= leaf[2 * k + 2 - LEAVES] + leaf[2 * k + 3 - LEAVES];
					end
				end
			end else begin : g_from_node
				always_ff @(posedge clk) begin
					if (en) node_sum_q[k] <= node_sum_q[2 * k + 1] + node_sum_q[2 * k + 2];
				end
			end
		end
		assign acc = node_sum_q[0];
	end else begin : g_flat
		assign acc = leaf[0];
	end

	// The sum is wider than 32 bits, so it is scaled in two partial products.
	always_ff @(posedge clk) begin
		if (en) begin
			prod_lo_s1 <= acc[31:0] * recip;
			prod_hi_s1 <= acc[ACC_W-1:32] * recip;
		end
	end

	assign lo_rnd = 65'(prod_lo_s1) + FIN_RND;
	assign scaled = R_W'(prod_hi_s1) + R_W'(lo_rnd[64:32]);

	always_ff @(posedge clk) begin
		if (en) noise_s2 <= (scaled > R_W'(ONE_Q16)) ? ONE_Q16 : scaled[NOISE_W-1:0];
	end

	assign noise_value = noise_s2;

endmodule

`default_nettype wire

/* rtl/value_noise_fbm_2d_unit.sv */
// ----------------------------------------------------------------------------
// value_noise_fbm_2d_unit
// Two-dimensional fractal value noise: one Q16.16 point in, one Q1.16 value out.
// ----------------------------------------------------------------------------
// Usage:
//   sample carries x_coord/y_coord, result carries noise_value, cfg writes the
//   octave count (index 0), lacunarity (index 1) and gain (index 2). A word
//   moves on each channel when valid and ready are both high.
//   All octaves run side by side in their own lanes, so a new sample is taken
//   every cycle unless the pipeline holds or the tables are being rebuilt. The
//   pipeline has eleven lane stages, the adder tree, one scaling multiply stage
//   and the output register.
//   After reset, and after each register write, the frequency and amplitude
//   tables are rebuilt and the reciprocal of the amplitude sum is found by a
//   bit-serial division; sample.ready is low while this is under way.
//   Registers must be written only while no sample is in flight; the unit
//   itself does not enforce this.
//   When result.ready is low with a word waiting, the whole pipeline holds
//   and sample.ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module value_noise_fbm_2d_unit import vnf_pkg::*; #(
	parameter int MAX_OCTAVES     = 8,
	parameter int COORD_FRAC_BITS = 16
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	vnf_sample_if.sink     sample,
	vnf_result_if.source   result,
	vnf_cfg_if.sink        cfg
);

	localparam int LEVELS = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 0;
	localparam int DEPTH  = LANE_LAT + LEVELS + FINAL_LAT;

	tbl_status_t       status;
	logic [TAB_W-1:0]  freq_tab [MAX_OCTAVES];
	logic [TAB_W-1:0]  amp_tab  [MAX_OCTAVES];
	logic [TERM_W-1:0] term     [MAX_OCTAVES];
	logic              lane_active [MAX_OCTAVES];
	logic [DEPTH-1:0]  vld_q;
	logic              pipe_en;
	logic              accept;

	vnf_table_builder #(
		.MAX_OCTAVES (MAX_OCTAVES)
	) u_table_builder (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.freq_tab (freq_tab),
		.amp_tab  (amp_tab),
		.status   (status)
	);

	// The pipeline moves unless a finished word is waiting at the output.
	assign pipe_en      = !vld_q[DEPTH-1] || result.ready;
	assign sample.ready = pipe_en && !status.busy;
	assign accept       = sample.valid && sample.ready;

	for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_lane
		assign lane_active[i] = (N_W'(i) < status.n_active);

		vnf_octave_lane #(
			.COORD_FRAC_BITS (COORD_FRAC_BITS)
		) u_lane (
			.clk     (clk),
			.en      (pipe_en),
			.x_coord (sample.x_coord),
			.y_coord (sample.y_coord),
			.freq    (freq_tab[i]),
			.amp     (amp_tab[i]),
			.active  (lane_active[i]),
			.term    (term[i])
		);
	end

	vnf_reduce #(
		.MAX_OCTAVES (MAX_OCTAVES)
	) u_reduce (
		.clk         (clk),
		.en          (pipe_en),
		.term        (term),
		.recip       (status.recip),
		.noise_value (result.noise_value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (pipe_en) begin
			vld_q <= {vld_q[DEPTH-2:0], accept};
		end
	end

	assign result.valid = vld_q[DEPTH-1];

`ifndef SYNTHESIS
	// A held pipeline keeps every stage's valid bit.
	a_stall_holds_valids: assert property (@(posedge clk) disable iff (!arst_n)
		!pipe_en |=> $stable(vld_q))
		else $error("valid bits moved during a stall");

	// The normalised value never exceeds one.
	a_result_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> result.noise_value <= ONE_Q16)
		else $error("noise value above one");
`endif

endmodule

`default_nettype wire

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Checks the fractal value noise unit against a bit-exact predictor of the
// octave hash, smoothstep blend and normalisation, over several register
// settings, with random idling on both channels and one long result stall.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench import vnf_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int OCTAVES = 8;
	localparam int CYCLE_LIMIT = 400000;

	logic clk;
	logic arst_n;

	vnf_sample_if sample_ch ();
	vnf_result_if result_ch ();
	vnf_cfg_if    cfg_ch ();

	value_noise_fbm_2d_unit #(.MAX_OCTAVES(OCTAVES), .COORD_FRAC_BITS(16)) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_ch.sink),
		.result (result_ch.source),
		.cfg    (cfg_ch.sink)
	);

	// Shadow copy of the registers and the tables derived from them.
	logic [OCT_CNT_W-1:0] sh_octaves;
	logic [LAC_W-1:0]     sh_lacunarity;
	logic [GAIN_W-1:0]    sh_gain;
	logic [31:0]          freq_tab [OCTAVES];
	logic [31:0]          amp_tab [OCTAVES];
	logic [31:0]          sum_recip;

	logic [NOISE_W-1:0] noise_expected [$];
	int mismatches;
	int results_seen;
	int items_sent;
	int cycles;
	int rx_wait;
	bit hold_off;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic logic [31:0] clip32(logic [63:0] v);
		return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
	endfunction

	function automatic int live_octaves();
		return (sh_octaves > OCTAVES) ? OCTAVES : int'(sh_octaves);
	endfunction

	function automatic void refresh_tables();
		logic [63:0] total;
		int n;
		n = live_octaves();
		total = 0;
		freq_tab[0] = TAB_ONE;
		amp_tab[0] = TAB_ONE;
		for (int i = 1; i < OCTAVES; i++) begin
			freq_tab[i] = clip32((64'(freq_tab[i-1]) * sh_lacunarity) >> 12);
			amp_tab[i] = clip32((64'(amp_tab[i-1]) * sh_gain) >> 14);
		end
		for (int i = 0; i < n; i++)
			total += amp_tab[i];
		sum_recip = (n == 0 || total == 0) ? 32'd0 : clip32((64'd1 << 48) / total);
	endfunction

	function automatic logic [63:0] lattice_value(logic [31:0] cx, logic [31:0] cy);
		logic [31:0] h;
		logic [63:0] v;
		h = cx * HASH_K1 + cy * HASH_K2;
		h = (h ^ (h >> XS_SHIFT)) * HASH_K3;
		v = 64'(h[23:0]);
		return (v * 64'd16777217 + (64'd1 << 31)) >> 32;
	endfunction

	function automatic logic [63:0] ease(logic [63:0] t);
		return (t * t * (64'd196608 - 2 * t) + (64'd1 << 31)) >> 32;
	endfunction

	function automatic logic [63:0] mix(logic [63:0] a, logic [63:0] b, logic [63:0] s);
		return (a * (64'd65536 - s) + b * s + 64'd32768) >> 16;
	endfunction

	// Product of a coordinate and a frequency: floor cell (wrapped) and Q0.16 fraction.
	function automatic void scale_axis(logic signed [31:0] c, logic [31:0] f,
	                                   output logic [31:0] lat_cell, output logic [63:0] frac);
		logic signed [63:0] p;
		p = 64'(c) * $signed({32'd0, f});
		lat_cell = 32'(p >>> 32);
		frac = 64'(p[31:16]);
	endfunction

	function automatic logic [NOISE_W-1:0] predict_noise(logic signed [31:0] x,
	                                                     logic signed [31:0] y);
		logic [31:0] cx, cy;
		logic [63:0] tx, ty, sx, sy, a, b, v, acc, r;
		int n;
		n = live_octaves();
		acc = 0;
		for (int i = 0; i < n; i++) begin
			scale_axis(x, freq_tab[i], cx, tx);
			scale_axis(y, freq_tab[i], cy, ty);
			sx = ease(tx);
			sy = ease(ty);
			a = mix(lattice_value(cx, cy), lattice_value(cx + 1, cy), sx);
			b = mix(lattice_value(cx, cy + 1), lattice_value(cx + 1, cy + 1), sx);
			v = mix(a, b, sy);
			acc += (v * amp_tab[i] + 64'd32768) >> 16;
		end
		r = (n == 0) ? 64'd0 : (acc * sum_recip + (64'd1 << 31)) >> 32;
		if (r > 64'd65536)
			r = 64'd65536;
		return r[NOISE_W-1:0];
	endfunction

	// Valid stays high after a word unless the next one is preceded by a gap.
	task automatic send_sample(logic [31:0] x, logic [31:0] y);
		int gap;
		gap = $urandom_range(0, 17);
		if (gap != 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.x_coord <= x;
		sample_ch.y_coord <= y;
		do @(posedge clk); while (!sample_ch.ready);
		noise_expected.push_back(predict_noise(x, y));
		items_sent++;
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
		sample_ch.valid <= 1'b0;
		// Wait for every word in flight before touching a register.
		while (noise_expected.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		case (idx)
			REG_OCTAVE_COUNT: sh_octaves = val[OCT_CNT_W-1:0];
			REG_LACUNARITY:   sh_lacunarity = val;
			REG_GAIN:         sh_gain = val;
			default: ;
		endcase
		refresh_tables();
	endtask

	task automatic set_all(logic [15:0] oct, logic [15:0] lac, logic [15:0] g);
		write_reg(REG_OCTAVE_COUNT, oct);
		write_reg(REG_LACUNARITY, lac);
		write_reg(REG_GAIN, g);
	endtask

	task automatic random_burst(int count);
		for (int k = 0; k < count; k++) begin
			case ($urandom_range(0, 3))
				0: send_sample($urandom, $urandom);
				1: send_sample($urandom_range(0, 32'h000F_FFFF),
				               -$urandom_range(0, 32'h000F_FFFF));
				2: send_sample({{16{$urandom_range(0, 1) ? 1'b1 : 1'b0}}, 16'($urandom)},
				               $urandom_range(0, 65535));
				default: send_sample($urandom ^ 32'h8000_0000, $urandom & 32'hFFFF_0000);
			endcase
		end
	endtask

	task automatic test_reset_defaults();
		send_sample(32'h0, 32'h0);
		send_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_sample(32'h8000_0000, 32'h8000_0000);
		send_sample(32'hFFFF_FFFF, 32'h0000_FFFF);
		send_sample(32'h0000_8000, 32'hFFFF_8000);
		send_sample(32'h8000_0000, 32'h7FFF_FFFF);
		send_sample(32'h0001_0000, 32'h0002_0000);
	endtask

	task automatic test_zero_octaves();
		set_all(0, 8192, 8192);
		send_sample(32'h1234_5678, 32'h9ABC_DEF0);
		send_sample(32'h0, 32'h0);
	endtask

	task automatic test_octave_limits();
		// A count above the table size acts as the full table.
		set_all(15, 65535, 65535);
		send_sample(32'h7FFF_FFFF, 32'h8000_0000);
		send_sample(32'h0003_4567, 32'hFFF8_1234);
		send_sample(32'hFFFF_FFFF, 32'h0000_0001);
		set_all(8, 0, 0);
		send_sample(32'h0005_5555, 32'h000A_AAAA);
		send_sample(32'h8000_0000, 32'h7FFF_FFFF);
		set_all(1, 4096, 16384);
		send_sample(32'h0000_FFFF, 32'hFFFF_0001);
		random_burst(80);
	endtask

	task automatic test_random_settings();
		for (int ph = 0; ph < 5; ph++) begin
			set_all(16'($urandom_range(0, 15)), 16'($urandom), 16'($urandom));
			random_burst(90);
		end
	endtask

	task automatic test_backpressure();
		set_all(8, 8192, 8192);
		fork
			begin
				hold_off = 1'b1;
				repeat (300) @(posedge clk);
				hold_off = 1'b0;
			end
			for (int k = 0; k < 60; k++) begin
				sample_ch.valid <= 1'b1;
				sample_ch.x_coord <= $urandom;
				sample_ch.y_coord <= $urandom;
				do @(posedge clk); while (!sample_ch.ready);
				noise_expected.push_back(predict_noise(sample_ch.x_coord, sample_ch.y_coord));
				items_sent++;
			end
		join
		set_all(4, 8192, 8192);
		random_burst(40);
	endtask

	// Result side: a random wait after each word, and every accepted word checked in order.
	initial begin
		result_ch.ready = 1'b0;
		rx_wait = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (result_ch.valid && result_ch.ready) begin
				results_seen++;
				rx_wait = $urandom_range(0, 17);
				if (noise_expected.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result word %0d", result_ch.noise_value);
				end else begin
					logic [NOISE_W-1:0] want;
					want = noise_expected.pop_front();
					if (want !== result_ch.noise_value) begin
						mismatches++;
						if (mismatches <= 10)
							$display("noise_value mismatch: expected %0d, got %0d",
							         want, result_ch.noise_value);
					end
				end
			end
			if (hold_off || rx_wait != 0) begin
				result_ch.ready <= 1'b0;
				if (rx_wait != 0)
					rx_wait--;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("timeout after %0d cycles", cycles);
				$display("testbench failed");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		hold_off = 1'b0;
		mismatches = 0;
		results_seen = 0;
		items_sent = 0;
		sample_ch.valid = 1'b0;
		sample_ch.x_coord = '0;
		sample_ch.y_coord = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		sh_octaves = OCT_CNT_RST;
		sh_lacunarity = LAC_RST;
		sh_gain = GAIN_RST;
		refresh_tables();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_defaults();
		test_zero_octaves();
		test_octave_limits();
		test_random_settings();
		test_backpressure();
		sample_ch.valid <= 1'b0;
		while (noise_expected.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		$display("Covered %0d samples and %0d result words over default, extreme and",
		         items_sent, results_seen);
		$display("random register settings, with a long result stall.");
		if (mismatches == 0 && noise_expected.size() == 0) begin
			$display("testbench passed");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("testbench failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
